[rtl/core/tfc_pkg.sv]
// tfc_pkg: shared types, widths and constants of the timer frequency calibrator.
// Used by timer_frequency_calibrator, tfc_divider and tfc_checker. No dependencies.
`default_nettype none

package tfc_pkg;

  localparam int REF_W   = 24;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 24;
  localparam int PROD_W  = CNT_W + CFG_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [CFG_W-1:0] RST_POLL_LIMIT   = 24'd10000000;
  localparam logic [CFG_W-1:0] RST_WINDOW_TICKS = 24'd35795;
  localparam logic [CFG_W-1:0] RST_REFERENCE_HZ = 24'd3579545;

  localparam logic OP_START = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  localparam logic [1:0] REG_POLL_LIMIT   = 2'd0;
  localparam logic [1:0] REG_WINDOW_TICKS = 2'd1;
  localparam logic [1:0] REG_REFERENCE_HZ = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TIMEOUT    = 2'd1,
    ST_ZERO_TICKS = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV
  } state_t;

  typedef struct packed {
    logic             opcode;
    logic [REF_W-1:0] reference_count;
    logic [CNT_W-1:0] counter_value;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] measured_hz;
    status_t          status;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[rtl/core/timer_frequency_calibrator.sv]
// Measures a down-counting timer's frequency against a 24-bit wrapping reference counter.
// Start words and polls that need no division are handled without the divider; a poll that
// closes the window with nonzero ticks goes through the bit-serial divider (a multiply state,
// then 56 quotient bits at one a cycle), and no new word is taken until its result is loaded.
// Depends on tfc_pkg and tfc_divider.
`default_nettype none

module timer_frequency_calibrator (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire tfc_pkg::in_word_t         in_word,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output tfc_pkg::out_word_t             out_word,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tfc_pkg::APB_AW-1:0] paddr,
  input  wire logic [tfc_pkg::APB_DW-1:0] pwdata,
  output logic      [tfc_pkg::APB_DW-1:0] prdata,
  output logic                           pready
);
  import tfc_pkg::*;

  // config
  logic [CFG_W-1:0] poll_limit_r, window_r, ref_hz_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  // measurement state
  state_t           state_r, state_nxt;
  logic             measuring_r, measuring_nxt;
  logic [REF_W-1:0] start_ref_r, start_ref_nxt;
  logic [CNT_W-1:0] start_cnt_r, start_cnt_nxt;
  logic [REF_W-1:0] polls_r, polls_nxt;
  logic [CNT_W-1:0] cnt_ticks_r, cnt_ticks_nxt;
  logic [REF_W-1:0] ref_ticks_r, ref_ticks_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  // evaluation of an accepted word
  logic             in_acc;
  logic             is_start;
  logic [REF_W-1:0] ref_ticks_w;
  logic [CNT_W-1:0] cnt_ticks_w;
  logic [REF_W-1:0] polls_inc;
  logic             win_hit;
  logic             ev_emit;
  logic             ev_div;
  out_word_t        ev_word;

  // divider
  logic              div_start;
  div_stat_t         div_stat;
  logic [PROD_W-1:0] div_quo;
  logic [PROD_W-1:0] product;
  logic              div_load;
  logic              out_free;
  out_word_t         div_word;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      REG_POLL_LIMIT:   prdata = APB_DW'(poll_limit_r);
      REG_WINDOW_TICKS: prdata = APB_DW'(window_r);
      REG_REFERENCE_HZ: prdata = APB_DW'(ref_hz_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= RST_POLL_LIMIT;
      window_r     <= RST_WINDOW_TICKS;
      ref_hz_r     <= RST_REFERENCE_HZ;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POLL_LIMIT:   poll_limit_r <= pwdata[CFG_W-1:0];
        REG_WINDOW_TICKS: window_r     <= pwdata[CFG_W-1:0];
        REG_REFERENCE_HZ: ref_hz_r     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign is_start = in_word.opcode == OP_START;

  assign ref_ticks_w = in_word.reference_count - start_ref_r;
  assign cnt_ticks_w = start_cnt_r - in_word.counter_value;
  assign polls_inc   = polls_r + 1'b1;
  assign win_hit     = ref_ticks_w >= window_r;

  always_comb begin
    ev_emit       = 1'b0;
    ev_div        = 1'b0;
    ev_word       = '{measured_hz: '0, status: ST_TIMEOUT};
    measuring_nxt = measuring_r;
    start_ref_nxt = start_ref_r;
    start_cnt_nxt = start_cnt_r;
    polls_nxt     = polls_r;
    cnt_ticks_nxt = cnt_ticks_r;
    ref_ticks_nxt = ref_ticks_r;
    if (in_acc) begin
      if (is_start) begin
        start_ref_nxt = in_word.reference_count;
        start_cnt_nxt = in_word.counter_value;
        polls_nxt     = '0;
        measuring_nxt = poll_limit_r != '0;
        ev_emit       = poll_limit_r == '0;
      end else if (measuring_r) begin
        polls_nxt = polls_inc;
        if (win_hit) begin
          measuring_nxt = 1'b0;
          cnt_ticks_nxt = cnt_ticks_w;
          ref_ticks_nxt = ref_ticks_w;
          if (ref_ticks_w == '0 || cnt_ticks_w == '0) begin
            ev_emit = 1'b1;
            ev_word.status = ST_ZERO_TICKS;
          end else begin
            ev_div = 1'b1;
          end
        end else if (polls_inc >= poll_limit_r) begin
          measuring_nxt = 1'b0;
          ev_emit       = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && ev_div) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_stat.done && out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start = 1'b0;
    div_load  = 1'b0;
    unique case (state_r)
      S_IDLE: ;
      S_MUL:  div_start = 1'b1;
      S_DIV:  div_load  = div_stat.done && out_free;
      default: ;
    endcase
  end

  assign product = PROD_W'(cnt_ticks_r) * PROD_W'(ref_hz_r);

  tfc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (ref_ticks_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_comb begin
    if (div_quo == '0 || div_quo[PROD_W-1:CNT_W] != '0) begin
      div_word = '{measured_hz: '0, status: ST_RANGE};
    end else begin
      div_word = '{measured_hz: div_quo[CNT_W-1:0], status: ST_OK};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (in_acc && ev_emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = ev_word;
    end else if (div_load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = div_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      measuring_r <= 1'b0;
      start_ref_r <= '0;
      start_cnt_r <= '0;
      polls_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      measuring_r <= measuring_nxt;
      start_ref_r <= start_ref_nxt;
      start_cnt_r <= start_cnt_nxt;
      polls_r     <= polls_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_ticks_r <= cnt_ticks_nxt;
    ref_ticks_r <= ref_ticks_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

[rtl/core/tfc_divider.sv]
// tfc_divider: restoring bit-serial divider, one quotient bit per cycle.
// Depends on tfc_pkg.
`default_nettype none

module tfc_divider (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tfc_pkg::PROD_W-1:0] dividend,
  input  wire logic [tfc_pkg::REF_W-1:0]  divisor,
  output tfc_pkg::div_stat_t             stat,
  output logic      [tfc_pkg::PROD_W-1:0] quotient
);
  import tfc_pkg::*;

  logic [REF_W-1:0]     rem_r, rem_nxt;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [REF_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [REF_W:0]       trial;
  logic [REF_W:0]       diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[PROD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(PROD_W - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[REF_W-1:0] : trial[REF_W-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

[rtl/core/tfc_checker.sv]
// tfc_checker: port-level assertions for timer_frequency_calibrator, bound to the top level.
// Depends on tfc_pkg.
`default_nettype none

module tfc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire tfc_pkg::out_word_t  out_word
);
  import tfc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |-> out_word.measured_hz == '0)
    else $error("failed measurement carries a frequency");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_OK |-> out_word.measured_hz != '0)
    else $error("good measurement with zero frequency");

  a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input word taken while result word is blocked");

endmodule

bind timer_frequency_calibrator tfc_checker u_tfc_checker (.*);

`default_nettype wire

[tb/sv/tb_timer_frequency_calibrator.sv]
// Testbench for timer_frequency_calibrator: directed corner cases, a long output hold-off and
// randomized measurement sequences, checked word by word against an in-bench predictor.
// Depends on tfc_pkg and the calibrator RTL.
`timescale 1ns / 1ps

module tb_timer_frequency_calibrator;
  import tfc_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  timer_frequency_calibrator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predictor state and configuration copy
  logic [CFG_W-1:0] cal_limit  = RST_POLL_LIMIT;
  logic [CFG_W-1:0] cal_window = RST_WINDOW_TICKS;
  logic [CFG_W-1:0] cal_hz     = RST_REFERENCE_HZ;
  logic [REF_W-1:0] run_ref    = '0;
  logic [CNT_W-1:0] run_cnt    = '0;
  logic [REF_W-1:0] run_polls  = '0;
  bit               run_active = 1'b0;

  out_word_t        pending_freq[$];
  out_word_t        exp_w;
  int unsigned      mismatches  = 0;
  int unsigned      items_done  = 0;
  bit               tx_quiet    = 1'b0;
  bit               rx_quiet    = 1'b0;
  bit               rx_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit calib_predict(input in_word_t w, output out_word_t r);
    logic [REF_W-1:0] elapsed;
    logic [CNT_W-1:0] ticks;
    logic [63:0]      quot;
    r = '0;
    if (w.opcode == OP_START) begin
      run_ref   = w.reference_count;
      run_cnt   = w.counter_value;
      run_polls = '0;
      if (cal_limit == '0) begin
        run_active = 1'b0;
        r.status   = ST_TIMEOUT;
        return 1'b1;
      end
      run_active = 1'b1;
      return 1'b0;
    end
    if (!run_active) return 1'b0;
    run_polls = run_polls + 1'b1;
    elapsed   = w.reference_count - run_ref;
    if (elapsed >= cal_window) begin
      run_active = 1'b0;
      ticks      = run_cnt - w.counter_value;
      if (elapsed == '0 || ticks == '0) begin
        r.status = ST_ZERO_TICKS;
        return 1'b1;
      end
      quot = ({32'd0, ticks} * {40'd0, cal_hz}) / {40'd0, elapsed};
      if (quot == 64'd0 || quot > 64'h0000_0000_FFFF_FFFF) begin
        r.status = ST_RANGE;
      end else begin
        r.measured_hz = quot[31:0];
        r.status      = ST_OK;
      end
      return 1'b1;
    end
    if (run_polls >= cal_limit) begin
      run_active = 1'b0;
      r.status   = ST_TIMEOUT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    out_word_t   res;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (w.opcode == OP_START || run_active) items_done++;
    if (calib_predict(w, res)) pending_freq.push_back(res);
  endtask

  task automatic offer(input logic op, input logic [REF_W-1:0] ref_v,
                       input logic [CNT_W-1:0] cnt_v);
    in_word_t w;
    w.opcode          = op;
    w.reference_count = ref_v;
    w.counter_value   = cnt_v;
    send_word(w);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_freq.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [CFG_W-1:0] v);
    logic [7:0] junk;
    junk = 8'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_POLL_LIMIT:   cal_limit  = v;
      REG_WINDOW_TICKS: cal_window = v;
      REG_REFERENCE_HZ: cal_hz     = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] limit_v, input logic [CFG_W-1:0] window_v,
                            input logic [CFG_W-1:0] hz_v);
    settle();
    reg_write(REG_POLL_LIMIT, limit_v);
    reg_write(REG_WINDOW_TICKS, window_v);
    reg_write(REG_REFERENCE_HZ, hz_v);
  endtask

  // start word followed by polls whose reference time climbs toward the window, now and then random
  task automatic run_measurement(input int unsigned max_polls);
    logic [REF_W-1:0] r0;
    logic [REF_W-1:0] ref_v;
    logic [CNT_W-1:0] c;
    logic [31:0]      dec;
    int unsigned      el;
    int unsigned      step_max;
    int unsigned      nb;
    int unsigned      k;
    r0 = REF_W'($urandom);
    c  = $urandom;
    offer(OP_START, r0, c);
    el       = 0;
    step_max = (cal_window / 3 == 0) ? 1 : cal_window / 3;
    for (k = 0; k < max_polls && run_active; k++) begin
      el = el + $urandom_range(0, step_max);
      if (el > 32'h00FF_FFFF) el = 32'h00FF_FFFF;
      nb  = $urandom_range(0, 32);
      dec = $urandom;
      if (nb < 32) dec = dec & ((32'd1 << nb) - 32'd1);
      c     = c - dec;
      ref_v = ($urandom_range(0, 7) == 0) ? REF_W'($urandom) : r0 + el[REF_W-1:0];
      offer(OP_POLL, ref_v, c);
    end
  endtask

  task automatic test_default_config();
    offer(OP_START, 24'hFFFFF0, 32'hFFFF_FFFF);
    offer(OP_POLL, 24'hFFFFF0 + 24'd40000, 32'hFFFF_FFFF - 32'd1000000);
    offer(OP_POLL, 24'h000000, 32'h0000_0000);
  endtask

  task automatic test_zero_limit();
    set_config(24'd0, RST_WINDOW_TICKS, RST_REFERENCE_HZ);
    offer(OP_START, 24'h000000, 32'h0000_0000);
  endtask

  task automatic test_restart_full_window();
    set_config(24'd2, 24'hFFFFFF, 24'hFFFFFF);
    offer(OP_START, 24'h000000, 32'h0000_0000);
    offer(OP_POLL, 24'h000005, 32'h0001_2345);
    offer(OP_START, 24'h000100, 32'h8000_0000);
    offer(OP_POLL, 24'h0000FF, 32'h7FFF_FFFF);
  endtask

  task automatic test_limit_lowered();
    set_config(24'd5, 24'hFFFFFF, RST_REFERENCE_HZ);
    offer(OP_START, 24'h000010, 32'd1000);
    offer(OP_POLL, 24'h000020, 32'd900);
    offer(OP_POLL, 24'h000030, 32'd800);
    offer(OP_POLL, 24'h000040, 32'd700);
    settle();
    reg_write(REG_POLL_LIMIT, 24'd2);
    offer(OP_POLL, 24'h000050, 32'd600);
  endtask

  task automatic test_zero_ticks();
    set_config(24'd3, 24'd0, RST_REFERENCE_HZ);
    offer(OP_START, 24'hABCDEF, 32'd5);
    offer(OP_POLL, 24'hABCDEF, 32'd3);
    set_config(24'd3, 24'd1, RST_REFERENCE_HZ);
    offer(OP_START, 24'hFFFFFF, 32'hDEAD_BEEF);
    offer(OP_POLL, 24'h000000, 32'hDEAD_BEEF);
  endtask

  task automatic test_out_of_range();
    set_config(24'd3, 24'd1, 24'd0);
    offer(OP_START, 24'h000007, 32'd100);
    offer(OP_POLL, 24'h000008, 32'd99);
    set_config(24'd3, 24'd1, 24'hFFFFFF);
    offer(OP_START, 24'h000000, 32'hFFFF_FFFF);
    offer(OP_POLL, 24'h000001, 32'h0000_0000);
    set_config(24'd3, 24'd16, 24'd1);
    offer(OP_START, 24'h000000, 32'd50);
    offer(OP_POLL, 24'h000100, 32'd49);
  endtask

  task automatic test_output_hold();
    int unsigned i;
    set_config(24'd0, 24'd1, RST_REFERENCE_HZ);
    tx_quiet    = 1'b1;
    rx_hold_req = 1'b1;
    for (i = 0; i < 16; i++) offer(OP_START, REF_W'($urandom), CNT_W'($urandom));
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_phases();
    int unsigned      p;
    int unsigned      target;
    logic [CFG_W-1:0] lv;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    in_word_t         w;
    for (p = 0; p < 10; p++) begin
      case (p)
        0: set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        1: set_config(24'd1, 24'd1, 24'd1);
        2: set_config(24'd0, CFG_W'($urandom), CFG_W'($urandom));
        default: begin
          lv = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 12));
          case ($urandom_range(0, 4))
            0: wv = 24'd0;
            1: wv = 24'd1;
            2: wv = CFG_W'($urandom);
            default: wv = CFG_W'($urandom_range(2, 5000));
          endcase
          hv = ($urandom_range(0, 5) == 0) ? 24'd0 : CFG_W'($urandom);
          set_config(lv, wv, hv);
        end
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      target   = items_done + 150;
      while (items_done < target) begin
        if ($urandom_range(0, 9) == 0) begin
          w.opcode          = 1'($urandom);
          w.reference_count = REF_W'($urandom);
          w.counter_value   = $urandom;
          send_word(w);
        end else begin
          run_measurement($urandom_range(1, 12));
        end
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // result side: long stall on request, else random stall after each word and now and then while idle
  initial begin : result_sink
    int unsigned w;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ((out_valid && !out_stall) || $urandom_range(0, 15) == 0) begin
        w = rx_quiet ? 0 : $urandom_range(0, 6);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_freq.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: measured_hz %0d status %0d",
                   out_word.measured_hz, out_word.status);
      end else begin
        exp_w = pending_freq.pop_front();
        if (out_word.measured_hz !== exp_w.measured_hz)
          flag_mismatch("measured_hz", exp_w.measured_hz, out_word.measured_hz);
        if (out_word.status !== exp_w.status)
          flag_mismatch("status", 32'(exp_w.status), 32'(out_word.status));
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_zero_limit();
    test_restart_full_window();
    test_limit_lowered();
    test_zero_ticks();
    test_out_of_range();
    test_output_hold();
    test_random_phases();
    settle();
    if (mismatches == 0 && pending_freq.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
